@@ hw/rtl/tcw_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and constants of the text console writer.
// Depends on nothing; the front end, back end, top level, checker and bench import it.
package tcw_pkg;

  // Field widths of the item and result ports
  localparam int OP_W   = 3;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int COL_W  = 8;
  localparam int ROW_W  = 7;
  localparam int CELL_W = CHAR_W + ATTR_W;

  // Default geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // Queue depths
  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 2;

  // Operation codes on the item port
  localparam logic [OP_W-1:0] OP_PUT_CURSOR = 3'd0;
  localparam logic [OP_W-1:0] OP_PUT_AT     = 3'd1;
  localparam logic [OP_W-1:0] OP_BACKSPACE  = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd3;
  localparam logic [OP_W-1:0] OP_READ       = 3'd4;

  // Character and attribute constants
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0a;
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_ERR     = 8'h45;
  localparam logic [ATTR_W-1:0] ATTR_ERR     = 8'h4f;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0f;

  // Command kinds produced by the front end
  typedef enum logic [2:0] {
    K_PUT_CUR,
    K_PUT_POS,
    K_PUT_ERR,
    K_BACK,
    K_CLEAR,
    K_READ,
    K_READ_ERR,
    K_NOP
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [CHAR_W-1:0] chr;
    logic [ATTR_W-1:0] attr;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } cmd_t;

  typedef struct packed {
    logic              status;
    logic [COL_W-1:0]  cursor_column;
    logic [ROW_W-1:0]  cursor_line;
    logic              scrolled;
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attr;
  } res_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_BACK,
    ST_READ,
    ST_COPY,
    ST_COPY_LAST,
    ST_ZERO,
    ST_FILL
  } state_t;

endpackage

@@ hw/rtl/tcw_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/tcw_fifo.sv @@
`timescale 1ns / 1ps
// Small register FIFO used for the command and result queues.
// Depends on nothing.
module tcw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [IW-1:0]    wptr;
  logic [IW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             push_ok;
  logic             pop_ok;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push_ok) begin
        wptr <= (wptr == IW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop_ok) begin
        rptr <= (rptr == IW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        count <= count + 1'b1;
      end else if (pop_ok && !push_ok) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/tcw_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts items, classifies them into commands, queues them.
// Depends on tcw_pkg and tcw_fifo.
module tcw_front import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [OP_W-1:0]   operation,
  input  logic [CHAR_W-1:0] character,
  input  logic [ATTR_W-1:0] attribute,
  input  logic [COL_W-1:0]  column,
  input  logic [ROW_W-1:0]  line,
  input  logic [ATTR_W-1:0] default_attr,
  input  logic              init_busy,
  input  logic              cmd_pop,
  output logic              cmd_empty,
  output cmd_t              cmd
);

  cmd_t                  cmd_in;
  logic                  on_grid;
  logic                  q_full;
  logic [$bits(cmd_t)-1:0] q_rdata;

  assign on_grid = (column < COL_W'(COLUMNS)) && (line < ROW_W'(ROWS));
  assign full    = q_full || init_busy;
  assign cmd     = cmd_t'(q_rdata);

  always_comb begin
    cmd_in.chr  = character;
    cmd_in.attr = (attribute == '0) ? default_attr : attribute;
    cmd_in.col  = column;
    cmd_in.row  = line;
    unique case (operation)
      OP_PUT_CURSOR: cmd_in.kind = K_PUT_CUR;
      OP_PUT_AT:     cmd_in.kind = on_grid ? K_PUT_POS : K_PUT_ERR;
      OP_BACKSPACE:  cmd_in.kind = K_BACK;
      OP_CLEAR:      cmd_in.kind = K_CLEAR;
      OP_READ:       cmd_in.kind = on_grid ? K_READ : K_READ_ERR;
      default:       cmd_in.kind = K_NOP;
    endcase
  end

  tcw_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push && !full),
    .wdata (cmd_in),
    .full  (q_full),
    .pop   (cmd_pop),
    .rdata (q_rdata),
    .empty (cmd_empty)
  );

endmodule

@@ hw/rtl/tcw_back.sv @@
`timescale 1ns / 1ps
// Back end: executes commands on the screen store, tracks the cursor and
// queues results. Depends on tcw_pkg, tcw_ram and tcw_fifo.
module tcw_back import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [ATTR_W-1:0] default_attr,
  input  logic              cmd_empty,
  input  cmd_t              cmd,
  output logic              cmd_pop,
  output logic              init_busy,
  input  logic              res_pop,
  output logic              res_empty,
  output res_t              res
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam logic [AW-1:0]    LAST   = AW'(CELLS - 1);
  localparam logic [AW-1:0]    TOPROW = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0]    COLS_A = AW'(COLUMNS);
  localparam logic [COL_W-1:0] COL_END = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] ROW_END = ROW_W'(ROWS - 1);

  state_t            state, state_next;
  cmd_t              cmd_r;
  logic [AW-1:0]     pos_r;
  logic [COL_W-1:0]  cur_col, cur_col_next;
  logic [ROW_W-1:0]  cur_row, cur_row_next;
  logic [AW-1:0]     cur_lin, cur_lin_next;
  logic [AW-1:0]     rptr, rptr_next;
  logic [AW-1:0]     wptr, wptr_next;
  logic              pend, pend_next;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  logic              res_push;
  logic              res_full;
  res_t              res_in;
  logic [$bits(res_t)-1:0] res_q;

  logic [COL_W-1:0]  src_col;
  logic [ROW_W-1:0]  src_row;
  logic [AW-1:0]     src_lin;
  logic              is_nl;
  logic              at_eol;
  logic              wrap;

  assign init_busy = (state == ST_INIT);
  assign res       = res_t'(res_q);

  // Put at cursor starts from the cursor, put at position from the command
  always_comb begin
    if (cmd_r.kind == K_PUT_CUR) begin
      src_col = cur_col;
      src_row = cur_row;
      src_lin = cur_lin;
    end else begin
      src_col = cmd_r.col;
      src_row = cmd_r.row;
      src_lin = pos_r;
    end
    is_nl  = (cmd_r.chr == CHAR_NEWLINE);
    at_eol = is_nl || (src_col == COL_END);
    wrap   = at_eol && (src_row == ROW_END);
  end

  always_comb begin
    state_next   = state;
    cmd_pop      = 1'b0;
    cur_col_next = cur_col;
    cur_row_next = cur_row;
    cur_lin_next = cur_lin;
    rptr_next    = rptr;
    wptr_next    = wptr;
    pend_next    = pend;
    ram_we       = 1'b0;
    ram_waddr    = wptr;
    ram_wdata    = '0;
    ram_raddr    = rptr;
    res_push     = 1'b0;
    res_in.status    = 1'b0;
    res_in.scrolled  = 1'b0;
    res_in.cell_char = '0;
    res_in.cell_attr = '0;

    unique case (state)
      ST_INIT: begin
        ram_we = 1'b1;
        if (wptr == LAST) begin
          wptr_next  = '0;
          state_next = ST_IDLE;
        end else begin
          wptr_next = wptr + 1'b1;
        end
      end

      ST_IDLE: begin
        if (!cmd_empty && !res_full) begin
          cmd_pop    = 1'b1;
          state_next = ST_EXEC;
        end
      end

      ST_EXEC: begin
        unique case (cmd_r.kind)
          K_PUT_CUR, K_PUT_POS: begin
            if (!is_nl) begin
              ram_we    = 1'b1;
              ram_waddr = src_lin;
              ram_wdata = {cmd_r.attr, cmd_r.chr};
            end
            if (wrap) begin
              // Land on the start of the bottom row, then scroll
              cur_col_next = '0;
              cur_row_next = ROW_END;
              cur_lin_next = TOPROW;
              wptr_next    = '0;
              rptr_next    = COLS_A;
              pend_next    = 1'b0;
              state_next   = (CELLS == COLUMNS) ? ST_ZERO : ST_COPY;
            end else begin
              cur_col_next = at_eol ? '0 : src_col + 1'b1;
              cur_row_next = at_eol ? src_row + 1'b1 : src_row;
              cur_lin_next = is_nl ? src_lin - AW'(src_col) + COLS_A : src_lin + 1'b1;
              res_push     = 1'b1;
              state_next   = ST_IDLE;
            end
          end
          K_PUT_ERR: begin
            ram_we        = 1'b1;
            ram_waddr     = LAST;
            ram_wdata     = {ATTR_ERR, CHAR_ERR};
            res_in.status = 1'b1;
            res_push      = 1'b1;
            state_next    = ST_IDLE;
          end
          K_BACK: begin
            if (cur_lin != '0) begin
              cur_lin_next = cur_lin - 1'b1;
              if (cur_col == '0) begin
                cur_col_next = COL_END;
                cur_row_next = cur_row - 1'b1;
              end else begin
                cur_col_next = cur_col - 1'b1;
              end
            end
            ram_raddr  = cur_lin_next;
            state_next = ST_BACK;
          end
          K_CLEAR: begin
            cur_col_next = '0;
            cur_row_next = '0;
            cur_lin_next = '0;
            wptr_next    = '0;
            state_next   = ST_FILL;
          end
          K_READ: begin
            ram_raddr  = pos_r;
            state_next = ST_READ;
          end
          K_READ_ERR: begin
            res_in.status = 1'b1;
            res_push      = 1'b1;
            state_next    = ST_IDLE;
          end
          default: begin
            res_push   = 1'b1;
            state_next = ST_IDLE;
          end
        endcase
      end

      ST_BACK: begin
        // Keep the attribute, blank the character
        ram_we     = 1'b1;
        ram_waddr  = cur_lin;
        ram_wdata  = {ram_rdata[CELL_W-1:CHAR_W], CHAR_SPACE};
        res_push   = 1'b1;
        state_next = ST_IDLE;
      end

      ST_READ: begin
        res_in.cell_char = ram_rdata[CHAR_W-1:0];
        res_in.cell_attr = ram_rdata[CELL_W-1:CHAR_W];
        res_push         = 1'b1;
        state_next       = ST_IDLE;
      end

      ST_COPY: begin
        // Read one row ahead, write each read back in the following cycle
        ram_raddr = rptr;
        if (pend) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          wptr_next = wptr + 1'b1;
        end
        pend_next = 1'b1;
        if (rptr == LAST) begin
          state_next = ST_COPY_LAST;
        end else begin
          rptr_next = rptr + 1'b1;
        end
      end

      ST_COPY_LAST: begin
        ram_we     = 1'b1;
        ram_wdata  = ram_rdata;
        wptr_next  = wptr + 1'b1;
        state_next = ST_ZERO;
      end

      ST_ZERO: begin
        ram_we = 1'b1;
        if (wptr == LAST) begin
          res_in.scrolled = 1'b1;
          res_push        = 1'b1;
          state_next      = ST_IDLE;
        end else begin
          wptr_next = wptr + 1'b1;
        end
      end

      ST_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = {default_attr, CHAR_SPACE};
        if (wptr == LAST) begin
          res_push   = 1'b1;
          state_next = ST_IDLE;
        end else begin
          wptr_next = wptr + 1'b1;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    res_in.cursor_column = cur_col_next;
    res_in.cursor_line   = cur_row_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_INIT;
      cur_col <= '0;
      cur_row <= '0;
      cur_lin <= '0;
      rptr    <= '0;
      wptr    <= '0;
      pend    <= 1'b0;
    end else begin
      state   <= state_next;
      cur_col <= cur_col_next;
      cur_row <= cur_row_next;
      cur_lin <= cur_lin_next;
      rptr    <= rptr_next;
      wptr    <= wptr_next;
      pend    <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cmd_r <= cmd;
      pos_r <= AW'(cmd.row) * COLS_A + AW'(cmd.col);
    end
  end

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tcw_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (res_pop),
    .rdata (res_q),
    .empty (res_empty)
  );

endmodule

@@ hw/rtl/text_console_writer_core.sv @@
`timescale 1ns / 1ps
// Text console writer top level: config register, front end and back end.
// Depends on tcw_pkg, tcw_front and tcw_back.
//
// Usage:
//   Items enter through push/full: a transaction completes on a clock edge
//   with push high and full low. Results leave through empty/pop: the oldest
//   result sits on the result ports while empty is low and is taken on an
//   edge with pop high. Every item gives exactly one result, in order.
//   default_attr is written through cfg_valid/cfg_ready/cfg_data; cfg_ready
//   is always high. Write it only while the block is idle.
//   Timing: the back end handles a character, newline, error or nop item in
//   its execute state alone, backspace and cell read there and in a further
//   state, and clear and an item that scrolls there and in a sweep of the
//   screen store at one write per cycle (a scroll copies the rows up, then
//   blanks the bottom row).
//   A two-entry command queue lets the front end keep taking items while the
//   back end works.
//   Reset: rst clears the cursor and queues and sets default_attr to 0x0f,
//   then the back end zeroes every cell of the screen store, holding full
//   high meanwhile.
//   Stall: when pop stays low, the result queue fills, the back end holds
//   off and the command queue fills until full rises.
module text_console_writer_core import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [OP_W-1:0]   operation,
  input  logic [CHAR_W-1:0] character,
  input  logic [ATTR_W-1:0] attribute,
  input  logic [COL_W-1:0]  column,
  input  logic [ROW_W-1:0]  line,
  output logic              empty,
  input  logic              pop,
  output logic              status,
  output logic [COL_W-1:0]  cursor_column,
  output logic [ROW_W-1:0]  cursor_line,
  output logic              scrolled,
  output logic [CHAR_W-1:0] cell_char,
  output logic [ATTR_W-1:0] cell_attr,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [ATTR_W-1:0] cfg_data
);

  logic [ATTR_W-1:0] default_attr;
  logic              init_busy;
  logic              cmd_pop;
  logic              cmd_empty;
  cmd_t              cmd;
  res_t              res;

  // Config writes are always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_attr <= ATTR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      default_attr <= cfg_data;
    end
  end

  // Front end: classify and queue each incoming transaction
  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .operation    (operation),
    .character    (character),
    .attribute    (attribute),
    .column       (column),
    .line         (line),
    .default_attr (default_attr),
    .init_busy    (init_busy),
    .cmd_pop      (cmd_pop),
    .cmd_empty    (cmd_empty),
    .cmd          (cmd)
  );

  // Back end: execute commands on the screen store and queue results
  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .default_attr (default_attr),
    .cmd_empty    (cmd_empty),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop),
    .init_busy    (init_busy),
    .res_pop      (pop),
    .res_empty    (empty),
    .res          (res)
  );

  // Unpack the head result onto the ports
  assign status        = res.status;
  assign cursor_column = res.cursor_column;
  assign cursor_line   = res.cursor_line;
  assign scrolled      = res.scrolled;
  assign cell_char     = res.cell_char;
  assign cell_attr     = res.cell_attr;

endmodule

@@ hw/rtl/tcw_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the text console writer, bound to the top level.
// Depends on tcw_pkg and text_console_writer_core.
module tcw_checker import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input logic              clk,
  input logic              rst,
  input logic              push,
  input logic              full,
  input logic [OP_W-1:0]   operation,
  input logic [CHAR_W-1:0] character,
  input logic [ATTR_W-1:0] attribute,
  input logic [COL_W-1:0]  column,
  input logic [ROW_W-1:0]  line,
  input logic              empty,
  input logic              pop,
  input logic              status,
  input logic [COL_W-1:0]  cursor_column,
  input logic [ROW_W-1:0]  cursor_line,
  input logic              scrolled,
  input logic [CHAR_W-1:0] cell_char,
  input logic [ATTR_W-1:0] cell_attr,
  input logic              cfg_valid,
  input logic              cfg_ready,
  input logic [ATTR_W-1:0] cfg_data
);

  // Leaving reset: no result waiting, no item taken during the store sweep
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (empty && full))
    else $error("queues not quiet right after reset");

  // A waiting result holds while it is not taken
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(status) && $stable(cursor_column)
      && $stable(cursor_line) && $stable(scrolled) && $stable(cell_char)
      && $stable(cell_attr)))
    else $error("result changed while stalled");

  // The cursor stays on the grid
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ((cursor_column < COL_W'(COLUMNS)) && (cursor_line < ROW_W'(ROWS))))
    else $error("cursor off the grid");

  // A scroll lands the cursor at the start of the bottom row
  a_scroll_cursor: assert property (@(posedge clk) disable iff (rst)
    (!empty && scrolled) |-> ((cursor_column == '0) && (cursor_line == ROW_W'(ROWS - 1))
      && !status))
    else $error("scroll left the cursor in the wrong place");

  // An error result never carries cell data
  a_error_no_data: assert property (@(posedge clk) disable iff (rst)
    (!empty && status) |-> ((cell_char == '0) && (cell_attr == '0)))
    else $error("error result carries cell data");

endmodule

bind text_console_writer_core tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (.*);

@@ bench/tb_text_console_writer_core.sv @@
`timescale 1ns / 1ps
// Self-checking bench for text_console_writer_core: random and directed screen commands,
// checked against a cycle-free mirror of the screen, cursor and default attribute.
// Depends on tcw_pkg and text_console_writer_core.
module tb_text_console_writer_core;
  import tcw_pkg::*;

  localparam int COLS  = COLUMNS_DEF;
  localparam int ROWS_N = ROWS_DEF;
  localparam int CELLS = COLS * ROWS_N;

  // Operation codes the block must ignore
  localparam logic [OP_W-1:0] OP_IGNORED_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_IGNORED_LAST  = 3'd7;

  // A full-screen sweep (clear or scroll) is the slowest thing the block does;
  // allow many of those back to back before declaring a hang.
  localparam int QUIET_LIMIT     = 20000;
  localparam int ITEMS_PER_PHASE = 256;
  localparam int SETTLE_CYCLES   = 2 * CELLS + 50;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] chr;
    logic [ATTR_W-1:0] attr;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } console_cmd_t;

  // Ports of the block; every input starts at a known value
  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              push = 1'b0;
  logic              full;
  logic [OP_W-1:0]   operation = '0;
  logic [CHAR_W-1:0] character = '0;
  logic [ATTR_W-1:0] attribute = '0;
  logic [COL_W-1:0]  column = '0;
  logic [ROW_W-1:0]  line = '0;
  logic              empty;
  logic              pop = 1'b0;
  logic              status;
  logic [COL_W-1:0]  cursor_column;
  logic [ROW_W-1:0]  cursor_line;
  logic              scrolled;
  logic [CHAR_W-1:0] cell_char;
  logic [ATTR_W-1:0] cell_attr;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [ATTR_W-1:0] cfg_data = '0;

  text_console_writer_core #(
    .COLUMNS(COLS),
    .ROWS(ROWS_N)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .operation(operation),
    .character(character),
    .attribute(attribute),
    .column(column),
    .line(line),
    .empty(empty),
    .pop(pop),
    .status(status),
    .cursor_column(cursor_column),
    .cursor_line(cursor_line),
    .scrolled(scrolled),
    .cell_char(cell_char),
    .cell_attr(cell_attr),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mirror of the block's state
  logic [CELL_W-1:0] screen_mirror [CELLS];
  int                cursor_pos;
  logic [ATTR_W-1:0] attr_default;

  // Commands waiting for the driver, replies waiting for the block
  console_cmd_t cmd_backlog [$];
  res_t         reply_q [$];

  // Bookkeeping shared between processes; all of it moves on the rising edge only
  int items_queued = 0;
  int items_accepted = 0;
  int replies_seen = 0;
  int error_count = 0;
  bit item_taken = 1'b0;

  // --------------------------------------------------------------------------
  // Screen mirror
  // --------------------------------------------------------------------------
  function automatic void reset_mirror();
    for (int i = 0; i < CELLS; i++) screen_mirror[i] = '0;
    cursor_pos   = 0;
    attr_default = ATTR_RESET;
  endfunction

  // Write a character (or take a newline) at a linear cell; return 1 on scroll.
  function automatic bit place_char(int pos, logic [CHAR_W-1:0] ch, logic [ATTR_W-1:0] attr);
    int next_pos;
    if (attr == '0) attr = attr_default;
    if (pos >= CELLS) pos = CELLS - 1;
    if (ch == CHAR_NEWLINE) begin
      next_pos = (pos / COLS + 1) * COLS;
    end else begin
      screen_mirror[pos] = {attr, ch};
      next_pos = pos + 1;
    end
    if (next_pos >= CELLS) begin
      // Shift every row up by one and blank the bottom row
      for (int i = 0; i < CELLS; i++) begin
        if (i + COLS < CELLS) screen_mirror[i] = screen_mirror[i + COLS];
        else screen_mirror[i] = '0;
      end
      cursor_pos = next_pos - COLS;
      return 1'b1;
    end
    cursor_pos = next_pos;
    return 1'b0;
  endfunction

  // Apply one command to the mirror and return the reply the block owes for it.
  function automatic res_t apply_console_op(console_cmd_t c);
    res_t r;
    bit   on_grid;
    int   pos;
    r = '0;
    on_grid = (int'(c.col) < COLS) && (int'(c.row) < ROWS_N);
    pos = int'(c.row) * COLS + int'(c.col);
    case (c.op)
      OP_PUT_CURSOR: r.scrolled = place_char(cursor_pos, c.chr, c.attr);
      OP_PUT_AT: begin
        if (on_grid) begin
          r.scrolled = place_char(pos, c.chr, c.attr);
        end else begin
          // Off-grid put: flag it in the last cell, cursor stays
          screen_mirror[CELLS - 1] = {ATTR_ERR, CHAR_ERR};
          r.status = 1'b1;
        end
      end
      OP_BACKSPACE: begin
        if (cursor_pos > 0) cursor_pos--;
        screen_mirror[cursor_pos][CHAR_W-1:0] = CHAR_SPACE;
      end
      OP_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen_mirror[i] = {attr_default, CHAR_SPACE};
        cursor_pos = 0;
      end
      OP_READ: begin
        if (on_grid) begin
          r.cell_char = screen_mirror[pos][CHAR_W-1:0];
          r.cell_attr = screen_mirror[pos][CELL_W-1:CHAR_W];
        end else begin
          r.status = 1'b1;
        end
      end
      default: ;
    endcase
    r.cursor_column = COL_W'(cursor_pos % COLS);
    r.cursor_line   = ROW_W'(cursor_pos / COLS);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_cmd(input console_cmd_t c);
    cmd_backlog.push_back(c);
    items_queued++;
  endtask

  task automatic queue_fields(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                              input logic [ATTR_W-1:0] attr, input int col, input int row);
    console_cmd_t c;
    c.op   = op;
    c.chr  = ch;
    c.attr = attr;
    c.col  = COL_W'(col);
    c.row  = ROW_W'(row);
    queue_cmd(c);
  endtask

  // Mostly legal traffic: lots of typing and reads, some jumps to the bottom row
  // so the screen scrolls, rare clears since each one sweeps the whole store.
  function automatic console_cmd_t random_command();
    console_cmd_t c;
    int           pick;
    c.chr  = CHAR_W'($urandom);
    c.attr = ($urandom_range(0, 3) == 0) ? '0 : ATTR_W'($urandom);
    c.col  = COL_W'($urandom);
    c.row  = ROW_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      c.op = OP_PUT_CURSOR;
      if ($urandom_range(0, 7) == 0) c.chr = CHAR_NEWLINE;
    end else if (pick < 55) begin
      c.op = OP_PUT_AT;
      if ($urandom_range(0, 7) == 0) c.chr = CHAR_NEWLINE;
      if ($urandom_range(0, 99) < 88) begin
        c.col = COL_W'($urandom_range(0, COLS - 1));
        c.row = ($urandom_range(0, 3) == 0) ? ROW_W'(ROWS_N - 1)
                                            : ROW_W'($urandom_range(0, ROWS_N - 1));
      end
    end else if (pick < 65) begin
      c.op = OP_BACKSPACE;
    end else if (pick < 67) begin
      c.op = OP_CLEAR;
    end else if (pick < 97) begin
      c.op = OP_READ;
      if ($urandom_range(0, 9) != 0) begin
        c.col = COL_W'($urandom_range(0, COLS - 1));
        c.row = ROW_W'($urandom_range(0, ROWS_N - 1));
      end
    end else begin
      c.op = OP_W'($urandom_range(OP_IGNORED_FIRST, OP_IGNORED_LAST));
    end
    return c;
  endfunction

  // Hand-picked corners: empty screen, default attribute, both scroll paths,
  // every off-grid flavor, backspace at the origin, clear and ignored codes.
  task automatic load_directed();
    queue_fields(OP_READ, 8'h00, 8'h00, 0, 0);
    queue_fields(OP_PUT_CURSOR, 8'h41, 8'h00, 0, 0);
    queue_fields(OP_PUT_CURSOR, 8'hff, 8'hff, 0, 0);
    queue_fields(OP_PUT_CURSOR, 8'h00, 8'h01, 0, 0);
    queue_fields(OP_PUT_CURSOR, CHAR_NEWLINE, 8'h00, 0, 0);
    queue_fields(OP_PUT_AT, 8'h5a, 8'h1e, 0, 0);
    queue_fields(OP_READ, 8'h00, 8'h00, 0, 0);
    queue_fields(OP_PUT_AT, 8'h78, 8'h00, COLS - 1, ROWS_N - 1);
    queue_fields(OP_PUT_AT, CHAR_NEWLINE, 8'h2a, 5, ROWS_N - 1);
    queue_fields(OP_PUT_AT, 8'h51, 8'h00, COLS, 0);
    queue_fields(OP_PUT_AT, 8'h52, 8'h00, 0, ROWS_N);
    queue_fields(OP_PUT_AT, 8'h53, 8'hff, 255, 127);
    queue_fields(OP_READ, 8'h00, 8'h00, COLS - 1, ROWS_N - 1);
    queue_fields(OP_READ, 8'hff, 8'hff, COLS, 3);
    queue_fields(OP_READ, 8'h00, 8'h00, 0, 127);
    queue_fields(OP_BACKSPACE, 8'hff, 8'hff, 255, 127);
    queue_fields(OP_CLEAR, 8'h00, 8'h00, 0, 0);
    queue_fields(OP_BACKSPACE, 8'h00, 8'h00, 0, 0);
    queue_fields(OP_READ, 8'h00, 8'h00, 0, 0);
    queue_fields(OP_PUT_AT, 8'h71, 8'h00, COLS - 2, ROWS_N - 1);
    queue_fields(OP_PUT_CURSOR, 8'h72, 8'h00, 0, 0);
    for (int op = OP_IGNORED_FIRST; op <= OP_IGNORED_LAST; op++)
      queue_fields(OP_W'(op), CHAR_W'($urandom), ATTR_W'($urandom), $urandom_range(0, 255),
                   $urandom_range(0, 127));
  endtask

  // Return on a falling edge once every queued command is in and answered.
  task automatic wait_drained();
    do @(negedge clk);
    while (items_accepted != items_queued || reply_q.size() != 0);
  endtask

  // Write the default attribute; call only while the block is drained.
  task automatic write_default_attr(input logic [ATTR_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic note_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  // --------------------------------------------------------------------------
  // Driver: feed commands in bursts, with random gaps between bursts
  // --------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left = 0;

  always @(negedge clk) begin : drive_commands
    console_cmd_t nxt;
    if (rst) begin
      push <= 1'b0;
    end else if (!push || item_taken) begin
      // Slot is free: either sit out the gap or present the next command
      if (gap_left > 0) begin
        push     <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (cmd_backlog.size() > 0) begin
        nxt = cmd_backlog.pop_front();
        push      <= 1'b1;
        operation <= nxt.op;
        character <= nxt.chr;
        attribute <= nxt.attr;
        column    <= nxt.col;
        line      <= nxt.row;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          case ($urandom_range(0, 7))
            0, 1, 2, 3: gap_left <= 0;
            4, 5, 6:    gap_left <= $urandom_range(1, 4);
            default:    gap_left <= $urandom_range(5, 20);
          endcase
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        push <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: pop on a rotating pattern, with occasional long hold-offs that
  // back the block up until full rises
  // --------------------------------------------------------------------------
  logic [15:0] pop_pattern = 16'hffff;
  int          pattern_age = 0;
  int          hold_left = 0;
  int          next_hold_at = 60;

  always @(negedge clk) begin : drive_pop
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      pop       <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (replies_seen >= next_hold_at) begin
      pop          <= 1'b0;
      hold_left    <= $urandom_range(60, 150);
      next_hold_at <= next_hold_at + 450;
    end else begin
      pop <= pop_pattern[0];
      if (pattern_age == 0) begin
        // Pick a new mood: free flowing, even, mostly popping or mostly stalled
        case ($urandom_range(0, 3))
          0:       pop_pattern <= 16'hffff;
          1:       pop_pattern <= 16'($urandom);
          2:       pop_pattern <= 16'($urandom | $urandom);
          default: pop_pattern <= 16'($urandom & $urandom);
        endcase
        pattern_age <= 31;
      end else begin
        pop_pattern <= {pop_pattern[0], pop_pattern[15:1]};
        pattern_age <= pattern_age - 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on every accepted command, check every accepted reply
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch_ports
    console_cmd_t c;
    res_t         want;
    if (rst) begin
      item_taken <= 1'b0;
      reset_mirror();
    end else begin
      item_taken <= push && !full;
      if (cfg_valid && cfg_ready) attr_default = cfg_data;
      if (push && !full) begin
        c = '{op: operation, chr: character, attr: attribute, col: column, row: line};
        reply_q.push_back(apply_console_op(c));
        items_accepted++;
      end
      if (pop && !empty) begin
        replies_seen++;
        if (reply_q.size() == 0) begin
          note_mismatch("reply with nothing outstanding", 1, 0);
        end else begin
          want = reply_q.pop_front();
          if (status !== want.status) note_mismatch("status", status, want.status);
          if (cursor_column !== want.cursor_column)
            note_mismatch("cursor_column", cursor_column, want.cursor_column);
          if (cursor_line !== want.cursor_line)
            note_mismatch("cursor_line", cursor_line, want.cursor_line);
          if (scrolled !== want.scrolled) note_mismatch("scrolled", scrolled, want.scrolled);
          if (cell_char !== want.cell_char) note_mismatch("cell_char", cell_char, want.cell_char);
          if (cell_attr !== want.cell_attr) note_mismatch("cell_attr", cell_attr, want.cell_attr);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: drop the run if no transaction of any kind moves for too long
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin : watchdog
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[%0t] no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("text_console_writer_core verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence: directed corners at the reset attribute, then random phases,
  // each under a fresh default attribute written while the block is drained
  // --------------------------------------------------------------------------
  initial begin : run_phases
    logic [ATTR_W-1:0] phase_attr;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    load_directed();
    wait_drained();
    for (int p = 0; p < 6; p++) begin
      // Hit both extremes first, then arbitrary values
      if (p == 0) phase_attr = 8'hff;
      else if (p == 1) phase_attr = 8'h00;
      else phase_attr = ATTR_W'($urandom_range(1, 254));
      write_default_attr(phase_attr);
      @(posedge clk);
      repeat (ITEMS_PER_PHASE) queue_cmd(random_command());
      wait_drained();
    end
    // Give any stray reply time to show up after the last sweep
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (reply_q.size() != 0) note_mismatch("replies never delivered", 0, reply_q.size());
    if (error_count == 0) begin
      $display("text_console_writer_core verification clean");
    end else begin
      $display("text_console_writer_core verification failed");
    end
    $finish;
  end

endmodule
